// ----- rtl/core/foc_pkg.sv -----
`default_nettype none
package foc_pkg;

	localparam int SineDepth = 1024;
	localparam int SineAw = $clog2(SineDepth);

	localparam logic [2:0] RegTgtD = 3'd0;
	localparam logic [2:0] RegTgtQ = 3'd1;
	localparam logic [2:0] RegKp   = 3'd2;
	localparam logic [2:0] RegKi   = 3'd3;
	localparam logic [2:0] RegKd   = 3'd4;
	localparam logic [2:0] RegDt   = 3'd5;
	localparam logic [2:0] RegVlim = 3'd6;

	localparam logic OpRun   = 1'b0;
	localparam logic OpClear = 1'b1;

	// quarter-wave polynomial sine, q1.14, from a 16-bit phase
	function automatic logic signed [15:0] sine_of(input logic [15:0] p);
		logic [1:0] quad;
		logic [16:0] x;
		logic [33:0] t;
		logic [50:0] s;
		logic [67:0] y;
		logic [16:0] r;
		quad = p[15:14];
		x = {1'b0, p[13:0], 2'b00};
		if (quad[0])
			x = 17'd65536 - x;
		t = ({17'd0, x} * {17'd0, x}) >> 16;
		s = 51'd307;
		s = 51'd5223 - ((s * {17'd0, t}) >> 16);
		s = 51'd42334 - ((s * {17'd0, t}) >> 16);
		s = 51'd102944 - ((s * {17'd0, t}) >> 16);
		y = ((({17'd0, s} * {51'd0, x}) >> 16) + 68'd2) >> 2;
		r = (y > 68'd16384) ? 17'd16384 : y[16:0];
		sine_of = quad[1] ? -$signed({1'b0, r[14:0]}) : $signed({1'b0, r[14:0]});
	endfunction

	function automatic logic signed [15:0] sine_entry(input int k);
		logic [15:0] ph;
		ph = 16'((k * 65536) / SineDepth);
		sine_entry = sine_of(ph);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/foc_current_loop.sv -----
// foc current loop: clarke, park, d/q pid and voltage vector limit
//
// input stream s_axis: one beat per sample, tuser = op (0 run, 1 clear),
// tdata = phase a current, phase b current, rotor angle.
// output stream m_axis: one beat per input, tdata = d current, q current,
// d voltage, q voltage; tuser = vector limited.
// registers sit on an apb port at byte address 4*index; pready is always high.
// a run beat is worked through by a state sequencer: one shared 33x33 multiply
// handles most products; a one-bit-per-cycle divider does the derivative
// division (64 steps per axis) and, when the vector is scaled down, the two
// scaling divisions (32 steps each), with a bit-test square root (17 steps)
// before them. a clear beat goes straight to the done state, which raises
// m_axis_tvalid.
// s_axis_tready is low from acceptance until the result has been taken, so
// a stalled receiver holds the block. the result register holds its beat
// until m_axis_tready. after reset all controller state is zero and the
// registers hold their reset values; no clearing pass is needed.
`default_nettype none
module foc_current_loop
	import foc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// [15:0] phase_a_current, [31:16] phase_b_current, [47:32] rotor_angle
	input  wire logic [47:0] s_axis_tdata,
	// [0] op
	input  wire logic [0:0]  s_axis_tuser,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [15:0] d_current, [31:16] q_current, [47:32] d_voltage, [63:48] q_voltage
	output      logic [63:0] m_axis_tdata,
	// [0] vector_limited
	output      logic [0:0]  m_axis_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	typedef enum logic [4:0] {
		S_IDLE, S_TAB, S_BETA, S_PARK, S_ERR, S_PM, S_IM, S_IC, S_ITM, S_DM,
		S_DDIV, S_DFIN, S_OUT, S_MAG, S_SQRT, S_SCL, S_SDIV, S_SFIN, S_DONE
	} state_t;

	state_t state_q;
	logic signed [15:0] tgt_d_q, tgt_q_q;
	logic [23:0] kp_q, ki_q, kd_q;
	logic [31:0] dt_q;
	logic [14:0] vlim_q;
	logic signed [39:0] integ_q [2];
	logic signed [15:0] prev_q [2];
	logic signed [15:0] ia_q, ib_q;
	logic [15:0] ang_q;
	logic signed [17:0] beta_q;
	logic signed [15:0] sn_q, cs_q;
	logic signed [15:0] cur_q [2];
	logic signed [15:0] v_q [2];
	logic axis_q;
	logic [1:0] step_q;
	logic signed [16:0] err_q;
	logic signed [65:0] acc_q;
	logic signed [65:0] dnum_q;
	logic [6:0] cnt_q;
	logic [63:0] rem_q, quo_q, div_q;
	logic [31:0] mag_q;
	logic [16:0] root_q;
	logic neg_q, lim_q;
	logic [63:0] out_data_q;
	logic out_user_q, out_valid_q;

	// sine rom
	logic signed [15:0] sine_rom [SineDepth];
	always_comb begin
		for (int k = 0; k < SineDepth; k++)
			sine_rom[k] = sine_entry(k);
	end

	logic [SineAw-1:0] sidx, cidx;
	assign sidx = ang_q[15 -: SineAw];
	assign cidx = sidx + SineAw'(SineDepth / 4);

	assign pready = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;

	// register readback
	always_comb begin
		unique case (paddr[4:2])
			RegTgtD: prdata = {{16{tgt_d_q[15]}}, tgt_d_q};
			RegTgtQ: prdata = {{16{tgt_q_q[15]}}, tgt_q_q};
			RegKp:   prdata = {8'd0, kp_q};
			RegKi:   prdata = {8'd0, ki_q};
			RegKd:   prdata = {8'd0, kd_q};
			RegDt:   prdata = dt_q;
			RegVlim: prdata = {17'd0, vlim_q};
			default: prdata = 32'd0;
		endcase
	end

	// shared multiplier operands, selected by state
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_BETA: begin
				ma = 33'(ia_q) + 33'(ib_q) * 2;
				mb = 33'sd37837;
			end
			S_PARK: begin
				ma = step_q[0] ? 33'(beta_q) : 33'(ia_q);
				if (step_q[1])
					mb = step_q[0] ? 33'(cs_q) : -33'(sn_q);
				else
					mb = step_q[0] ? 33'(sn_q) : 33'(cs_q);
			end
			S_PM:  begin ma = 33'(err_q); mb = $signed({9'd0, kp_q}); end
			S_IM:  begin ma = 33'(err_q); mb = $signed({1'b0, dt_q}); end
			S_ITM: begin
				ma = 33'(integ_q[axis_q] >>> 20);
				mb = $signed({9'd0, ki_q});
			end
			S_DM:  begin
				ma = 33'(err_q) - 33'(prev_q[axis_q]);
				mb = $signed({9'd0, kd_q});
			end
			S_MAG: begin
				ma = 33'(v_q[step_q[0]]);
				mb = 33'(v_q[step_q[0]]);
			end
			S_SCL: begin
				ma = 33'(v_q[axis_q]);
				mb = $signed({18'd0, vlim_q});
			end
			default: ;
		endcase
		prod = ma * mb;
	end

	// integral low part product for exact ki*integ (second partial)
	logic signed [65:0] ilo;
	assign ilo = $signed({1'b0, integ_q[axis_q][19:0]}) * $signed({1'b0, ki_q});

	function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
		if (v > 66'sd32767) sat16 = 16'sh7fff;
		else if (v < -66'sd32768) sat16 = 16'sh8000;
		else sat16 = v[15:0];
	endfunction

	// integral clamp 0.8*vlim in q15.24: vlim*(2^26-4)/5 plus floor(4*vlim/5)
	logic [38:0] ilim_fr;
	logic signed [40:0] ilim;
	assign ilim_fr = 39'({vlim_q, 2'b00}) * 39'd3355444;
	assign ilim = 41'(vlim_q) * 41'd13421772 + 41'(ilim_fr[38:24]);

	logic [63:0] dtn;
	assign dtn = (dt_q == 32'd0) ? 64'd1 : {32'd0, dt_q};

	// restoring divide step
	logic [64:0] trial;
	assign trial = {rem_q, quo_q[63]} - {1'b0, div_q};

	// square root step on 32-bit magnitude: root bit test
	logic [16:0] rtry;
	logic [33:0] rsq;
	assign rtry = root_q | (17'd1 << cnt_q[4:0]);
	assign rsq = rtry * rtry;

	// p + i + d before the output clamp
	logic signed [65:0] pid_sum;
	assign pid_sum = acc_q + (neg_q ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_d_q <= '0;
			tgt_q_q <= '0;
			kp_q <= 24'd65536;
			ki_q <= 24'd3276800;
			kd_q <= '0;
			dt_q <= 32'd429497;
			vlim_q <= 15'd3072;
			integ_q[0] <= '0;
			integ_q[1] <= '0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				unique case (paddr[4:2])
					RegTgtD: tgt_d_q <= pwdata[15:0];
					RegTgtQ: tgt_q_q <= pwdata[15:0];
					RegKp:   kp_q <= pwdata[23:0];
					RegKi:   ki_q <= pwdata[23:0];
					RegKd:   kd_q <= pwdata[23:0];
					RegDt:   dt_q <= pwdata;
					RegVlim: vlim_q <= pwdata[14:0];
					default: ;
				endcase
			end
			if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						ia_q <= s_axis_tdata[15:0];
						ib_q <= s_axis_tdata[31:16];
						ang_q <= s_axis_tdata[47:32];
						if (s_axis_tuser[0] == OpClear) begin
							integ_q[0] <= '0;
							integ_q[1] <= '0;
							prev_q[0] <= '0;
							prev_q[1] <= '0;
							out_data_q <= '0;
							out_user_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_TAB;
						end
					end
				end
				S_TAB: begin
					sn_q <= sine_rom[sidx];
					cs_q <= sine_rom[cidx];
					state_q <= S_BETA;
				end
				S_BETA: begin
					beta_q <= 18'((prod + 66'sd32768) >>> 16);
					step_q <= '0;
					acc_q <= '0;
					state_q <= S_PARK;
				end
				S_PARK: begin
					step_q <= step_q + 2'd1;
					if (step_q[0]) begin
						cur_q[step_q[1]] <= sat16((acc_q + prod + 66'sd8192) >>> 14);
						acc_q <= '0;
					end else begin
						acc_q <= prod;
					end
					if (step_q == 2'd3) begin
						axis_q <= 1'b0;
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					err_q <= 17'(sat16(66'((axis_q ? tgt_q_q : tgt_d_q))
						- 66'(cur_q[axis_q])));
					state_q <= S_PM;
				end
				S_PM: begin
					acc_q <= (prod + 66'sd32768) >>> 16;
					state_q <= S_IM;
				end
				S_IM: begin
					dnum_q <= 66'(integ_q[axis_q]) + ((prod + 66'sd128) >>> 8);
					state_q <= S_IC;
				end
				S_IC: begin
					if (dnum_q > 66'(ilim)) integ_q[axis_q] <= 40'(ilim);
					else if (dnum_q < -66'(ilim)) integ_q[axis_q] <= 40'(-ilim);
					else integ_q[axis_q] <= dnum_q[39:0];
					state_q <= S_ITM;
				end
				S_ITM: begin
					// ki*integ = (hi<<20)*ki + lo*ki, rounded >>40
					acc_q <= acc_q + (((prod <<< 20) + ilo + (66'sd1 <<< 39)) >>> 40);
					state_q <= S_DM;
				end
				S_DM: begin
					dnum_q <= prod <<< 16;
					neg_q <= prod[65];
					rem_q <= '0;
					quo_q <= prod[65] ? 64'(-(prod <<< 16)) : 64'(prod <<< 16);
					div_q <= dtn;
					cnt_q <= 7'd64;
					state_q <= S_DDIV;
				end
				S_DDIV: begin
					if (!trial[64]) rem_q <= trial[63:0];
					else rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], !trial[64]};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) state_q <= S_DFIN;
				end
				S_DFIN: begin
					if (pid_sum > $signed({51'd0, vlim_q})) v_q[axis_q] <= {1'b0, vlim_q};
					else if (pid_sum < -$signed({51'd0, vlim_q}))
						v_q[axis_q] <= -$signed({1'b0, vlim_q});
					else v_q[axis_q] <= pid_sum[15:0];
					prev_q[axis_q] <= err_q[15:0];
					if (axis_q) begin
						step_q <= '0;
						mag_q <= '0;
						state_q <= S_MAG;
					end else begin
						axis_q <= 1'b1;
						state_q <= S_ERR;
					end
				end
				S_MAG: begin
					mag_q <= mag_q + prod[31:0];
					step_q <= step_q + 2'd1;
					if (step_q[0]) begin
						root_q <= '0;
						cnt_q <= 7'd16;
						if (mag_q + prod[31:0] <= 32'({15'd0, vlim_q} * {15'd0, vlim_q})) begin
							lim_q <= 1'b0;
							state_q <= S_OUT;
						end else begin
							lim_q <= 1'b1;
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (rsq <= {2'd0, mag_q}) root_q <= rtry;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd0) begin
						axis_q <= 1'b0;
						state_q <= S_SCL;
					end
				end
				S_SCL: begin
					neg_q <= prod[65];
					rem_q <= '0;
					quo_q <= {(prod[65] ? 32'(-prod) : prod[31:0]), 32'd0};
					div_q <= 64'(root_q) +
						64'(34'(root_q) * 34'(root_q) < {2'd0, mag_q});
					cnt_q <= 7'd32;
					state_q <= S_SDIV;
				end
				S_SDIV: begin
					if (!trial[64]) rem_q <= trial[63:0];
					else rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], !trial[64]};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) state_q <= S_SFIN;
				end
				S_SFIN: begin
					v_q[axis_q] <= neg_q ? -quo_q[15:0] : quo_q[15:0];
					if (axis_q) state_q <= S_OUT;
					else begin
						axis_q <= 1'b1;
						state_q <= S_SCL;
					end
				end
				S_OUT: begin
					out_data_q <= {v_q[1], v_q[0], cur_q[1], cur_q[0]};
					out_user_q <= lim_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> m_axis_tvalid) else $error("result lost");
	a_vlim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (v_q[0] <= $signed({1'b0, vlim_q})
		&& v_q[0] >= -$signed({1'b0, vlim_q}))) else $error("d voltage over limit");
`endif

endmodule
`default_nettype wire
